[hw/rtl/scancode_to_ascii_decoder_defines.svh]
// assertion macros used by the scancode decoder top level
`ifndef SCANCODE_TO_ASCII_DECODER_DEFINES_SVH
`define SCANCODE_TO_ASCII_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/scd_pkg.sv]
// types, scancode constants and layout tables for the scancode decoder
package scd_pkg;

  // scancode bytes and key codes (release bit stripped)
  localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
  localparam int unsigned SC_REL_BIT   = 7;
  localparam logic [6:0] SC_ALT    = 7'h38;
  localparam logic [6:0] SC_CTRL   = 7'h1D;
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_CAPS   = 7'h3A;
  localparam logic [6:0] SC_TAB    = 7'h0F;
  localparam logic [6:0] SC_UP     = 7'h48;
  localparam logic [6:0] SC_DOWN   = 7'h50;
  localparam logic [6:0] SC_LEFT   = 7'h4B;
  localparam logic [6:0] SC_RIGHT  = 7'h4D;
  localparam logic [6:0] SC_HOME   = 7'h47;
  localparam logic [6:0] SC_END    = 7'h4F;

  // special key ids
  localparam logic [2:0] SK_UP    = 3'd0;
  localparam logic [2:0] SK_DOWN  = 3'd1;
  localparam logic [2:0] SK_LEFT  = 3'd2;
  localparam logic [2:0] SK_RIGHT = 3'd3;
  localparam logic [2:0] SK_HOME  = 3'd4;
  localparam logic [2:0] SK_END   = 3'd5;
  localparam logic [2:0] SK_TAB   = 3'd6;

  // ascii bounds and offsets
  localparam logic [6:0] ASC_LC_A  = 7'h61;
  localparam logic [6:0] ASC_LC_Z  = 7'h7A;
  localparam logic [6:0] ASC_UC_A  = 7'h41;
  localparam logic [6:0] ASC_UC_Z  = 7'h5A;
  localparam logic [6:0] CASE_DIFF = 7'd32;
  localparam logic [6:0] LC_CTRL_OFS = 7'h60;
  localparam logic [6:0] UC_CTRL_OFS = 7'h40;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic altgr;
    logic caps;
    logic prefix;
  } flags_t;

  typedef struct packed {
    logic       valid;
    logic       is_special;
    logic [6:0] char_code;
    logic [2:0] special_key;
  } result_t;

  function automatic logic [6:0] plain_lut(input logic [6:0] k);
    logic [6:0] c;
    case (k)
      7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33; 7'h05: c = 7'h34;
      7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37; 7'h09: c = 7'h38;
      7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h27; 7'h0E: c = 7'h08;
      7'h0F: c = 7'h09;
      7'h10: c = 7'h71; 7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72;
      7'h14: c = 7'h74; 7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69;
      7'h18: c = 7'h6F; 7'h19: c = 7'h70; 7'h1A: c = 7'h60; 7'h1B: c = 7'h2B;
      7'h1C: c = 7'h0A;
      7'h1E: c = 7'h61; 7'h1F: c = 7'h73; 7'h20: c = 7'h64; 7'h21: c = 7'h66;
      7'h22: c = 7'h67; 7'h23: c = 7'h68; 7'h24: c = 7'h6A; 7'h25: c = 7'h6B;
      7'h26: c = 7'h6C;
      7'h2C: c = 7'h7A; 7'h2D: c = 7'h78; 7'h2E: c = 7'h63; 7'h2F: c = 7'h76;
      7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D; 7'h33: c = 7'h2C;
      7'h34: c = 7'h2E; 7'h35: c = 7'h2D; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      7'h47: c = 7'h37; 7'h48: c = 7'h38; 7'h49: c = 7'h39; 7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34; 7'h4C: c = 7'h35; 7'h4D: c = 7'h36; 7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31; 7'h50: c = 7'h32; 7'h51: c = 7'h33; 7'h52: c = 7'h30;
      7'h53: c = 7'h2E; 7'h56: c = 7'h3C;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shift_lut(input logic [6:0] k);
    logic [6:0] c;
    case (k)
      7'h02: c = 7'h21; 7'h03: c = 7'h22; 7'h05: c = 7'h24; 7'h06: c = 7'h25;
      7'h07: c = 7'h26; 7'h08: c = 7'h2F; 7'h09: c = 7'h28; 7'h0A: c = 7'h29;
      7'h0B: c = 7'h3D; 7'h0C: c = 7'h3F; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
      7'h10: c = 7'h51; 7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52;
      7'h14: c = 7'h54; 7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49;
      7'h18: c = 7'h4F; 7'h19: c = 7'h50; 7'h1A: c = 7'h5E; 7'h1B: c = 7'h2A;
      7'h1C: c = 7'h0A;
      7'h1E: c = 7'h41; 7'h1F: c = 7'h53; 7'h20: c = 7'h44; 7'h21: c = 7'h46;
      7'h22: c = 7'h47; 7'h23: c = 7'h48; 7'h24: c = 7'h4A; 7'h25: c = 7'h4B;
      7'h26: c = 7'h4C;
      7'h2C: c = 7'h5A; 7'h2D: c = 7'h58; 7'h2E: c = 7'h43; 7'h2F: c = 7'h56;
      7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D; 7'h33: c = 7'h3B;
      7'h34: c = 7'h3A; 7'h35: c = 7'h5F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      7'h47: c = 7'h37; 7'h48: c = 7'h38; 7'h49: c = 7'h39; 7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34; 7'h4C: c = 7'h35; 7'h4D: c = 7'h36; 7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31; 7'h50: c = 7'h32; 7'h51: c = 7'h33; 7'h52: c = 7'h30;
      7'h53: c = 7'h2E; 7'h56: c = 7'h3E;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] altgr_lut(input logic [6:0] k);
    logic [6:0] c;
    case (k)
      7'h02: c = 7'h7C; 7'h03: c = 7'h40; 7'h04: c = 7'h23; 7'h05: c = 7'h7E;
      7'h09: c = 7'h5B; 7'h0A: c = 7'h5D; 7'h0C: c = 7'h5C;
      7'h28: c = 7'h7B; 7'h2B: c = 7'h7D;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/scd_in_if.sv]
// scancode input channel: valid/ready with one scancode byte
interface scd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

[hw/rtl/scd_out_if.sv]
// decoded key channel: valid/ready with character or special key payload
interface scd_out_if;
  logic       valid;
  logic       ready;
  logic       is_special;
  logic [6:0] char_code;
  logic [2:0] special_key;

  modport source (output valid, output is_special, output char_code,
                  output special_key, input ready);
  modport sink   (input valid, input is_special, input char_code,
                  input special_key, output ready);
endinterface

[hw/rtl/scd_decode.sv]
// single-pass scancode decode: modifier flag update and table lookup
module scd_decode (
  input  logic [7:0]      scan_byte,
  input  scd_pkg::flags_t flags,
  output scd_pkg::flags_t flags_nxt,
  output scd_pkg::result_t res
);
  import scd_pkg::*;

  logic [6:0] key;
  logic       is_rel;
  logic [6:0] c_plain;
  logic [6:0] c_shift;
  logic [6:0] c_altgr;
  logic       plain_lc;
  logic       plain_uc;

  assign key     = scan_byte[6:0];
  assign is_rel  = scan_byte[SC_REL_BIT];
  assign c_plain = plain_lut(key);
  assign c_shift = shift_lut(key);
  assign c_altgr = altgr_lut(key);
  assign plain_lc = (c_plain >= ASC_LC_A) && (c_plain <= ASC_LC_Z);
  assign plain_uc = (c_plain >= ASC_UC_A) && (c_plain <= ASC_UC_Z);

  always_comb begin
    flags_nxt = flags;
    res       = '0;
    if (scan_byte == SC_EXT_PREFIX) begin
      flags_nxt.prefix = 1'b1;
    end else if (is_rel) begin
      flags_nxt.prefix = 1'b0;
      if (key == SC_CTRL) flags_nxt.ctrl = 1'b0;
      if (flags.prefix) begin
        if (key == SC_ALT) flags_nxt.altgr = 1'b0;
      end else begin
        if (key == SC_LSHIFT || key == SC_RSHIFT) flags_nxt.shift = 1'b0;
      end
    end else if (flags.prefix) begin
      flags_nxt.prefix = 1'b0;
      res.is_special   = 1'b1;
      case (key)
        SC_ALT: begin
          flags_nxt.altgr = 1'b1;
          res.is_special  = 1'b0;
        end
        SC_CTRL: begin
          flags_nxt.ctrl = 1'b1;
          res.is_special = 1'b0;
        end
        SC_UP:    begin res.valid = 1'b1; res.special_key = SK_UP;    end
        SC_DOWN:  begin res.valid = 1'b1; res.special_key = SK_DOWN;  end
        SC_LEFT:  begin res.valid = 1'b1; res.special_key = SK_LEFT;  end
        SC_RIGHT: begin res.valid = 1'b1; res.special_key = SK_RIGHT; end
        SC_HOME:  begin res.valid = 1'b1; res.special_key = SK_HOME;  end
        SC_END:   begin res.valid = 1'b1; res.special_key = SK_END;   end
        default:  res.is_special = 1'b0;
      endcase
    end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
      flags_nxt.shift = 1'b1;
    end else if (key == SC_CTRL) begin
      flags_nxt.ctrl = 1'b1;
    end else if (key == SC_CAPS) begin
      flags_nxt.caps = ~flags.caps;
    end else if (key == SC_TAB) begin
      res.valid       = 1'b1;
      res.is_special  = 1'b1;
      res.special_key = SK_TAB;
    end else if (flags.altgr) begin
      res.valid     = (c_altgr != 7'h00);
      res.char_code = c_altgr;
    end else if (flags.ctrl) begin
      // ctrl folds letters onto control codes 1 to 26
      if (plain_lc) begin
        res.valid     = 1'b1;
        res.char_code = c_plain - LC_CTRL_OFS;
      end else if (plain_uc) begin
        res.valid     = 1'b1;
        res.char_code = c_plain - UC_CTRL_OFS;
      end
    end else if (flags.shift) begin
      res.valid     = (c_shift != 7'h00);
      res.char_code = c_shift;
    end else begin
      res.valid     = (c_plain != 7'h00);
      res.char_code = (flags.caps && plain_lc) ? (c_plain - CASE_DIFF) : c_plain;
    end
  end

endmodule

[hw/rtl/scancode_to_ascii_decoder.sv]
// top level of the set-1 scancode to ascii decoder
// Decodes a stream of set-1 keyboard scancode bytes (Spanish layout) into
// characters and special keys. Each byte is one transaction on in_ch; a key
// press gives at most one transaction on out_ch, either an ascii character
// (is_special low, char_code valid) or a special key id (is_special high:
// 0 up, 1 down, 2 left, 3 right, 4 home, 5 end, 6 tab). Releases, modifier
// presses, the 0xE0 prefix and unmapped keys give no output transaction.
// Shift, ctrl, AltGr, caps lock and the pending prefix are tracked inside.
// Throughput is one scancode per clock while out_ch takes results; each input
// transaction passes through the input register, the single-pass table decode
// and the result register. Back-pressure on out_ch only stalls the input side
// once both registers are full.
`include "scancode_to_ascii_decoder_defines.svh"

module scancode_to_ascii_decoder (
  input  logic      clk,
  input  logic      rst_n,
  scd_in_if.sink    in_ch,
  scd_out_if.source out_ch
);
  import scd_pkg::*;

  // input register stage
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // keyboard state
  flags_t flags_r;
  flags_t flags_nxt;

  // result register stage
  logic       out_vld_r;
  logic       out_special_r;
  logic [6:0] out_char_r;
  logic [2:0] out_key_r;

  result_t dec_res;
  logic    out_free;
  logic    dec_fire;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_vld_r || out_ch.ready;
  // the decoded byte moves on (and updates state) whenever the result slot can take it
  assign dec_fire = in_vld_r && out_free;
  assign in_ch.ready = !in_vld_r || dec_fire;

  scd_decode u_decode (
    .scan_byte (in_byte_r),
    .flags     (flags_r),
    .flags_nxt (flags_nxt),
    .res       (dec_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.scan_byte;
    end
  end

  // modifier and prefix flags advance once per decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (dec_fire) begin
      flags_r <= flags_nxt;
    end
  end

  // result register; bytes with no result leave it empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= dec_fire && dec_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_fire && dec_res.valid && out_free) begin
      out_special_r <= dec_res.is_special;
      out_char_r    <= dec_res.char_code;
      out_key_r     <= dec_res.special_key;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.is_special  = out_special_r;
  assign out_ch.char_code   = out_char_r;
  assign out_ch.special_key = out_key_r;

  // a special key result never carries a character, and a character result keeps its key id at zero
  `SCD_ASSERT_NOW(a_special_no_char, out_vld_r && out_special_r, out_char_r == 7'h00,
    "special key result carries a character code")
  `SCD_ASSERT_NOW(a_char_no_key, out_vld_r && !out_special_r, out_key_r == SK_UP,
    "character result carries a special key id")
  // a stalled result is not overwritten
  `SCD_ASSERT_NEXT(a_out_hold, out_vld_r && !out_ch.ready,
    out_vld_r && $stable(out_char_r) && $stable(out_key_r) && $stable(out_special_r),
    "pending result changed while stalled")
  // a decoded prefix byte leaves the prefix pending and produces nothing
  `SCD_ASSERT_NEXT(a_prefix_set, dec_fire && in_byte_r == SC_EXT_PREFIX,
    flags_r.prefix && !out_vld_r,
    "extended prefix not latched")

endmodule

[tb/tb_scancode_to_ascii_decoder.sv]
// self-checking testbench for the set-1 scancode to ascii decoder
`timescale 1ns / 100ps

module tb_scancode_to_ascii_decoder;
  import scd_pkg::*;

  // one decoded key as seen on the output channel
  typedef struct packed {
    logic       is_special;
    logic [6:0] char_code;
    logic [2:0] special_key;
  } key_event_t;

  // receiver back-pressure patterns
  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_MOSTLY,
    RDY_PERIODIC
  } stall_mode_e;

  localparam int RANDOM_ITEMS  = 1750;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst_n;

  scd_in_if  in_ch ();
  scd_out_if out_ch ();

  scancode_to_ascii_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // keyboard state mirrored by the predictor
  logic kb_shift;
  logic kb_ctrl;
  logic kb_altgr;
  logic kb_caps;
  logic kb_prefix;

  key_event_t pending_keys[$];
  int         error_count;
  int         items_sent;
  int         burst_left;

  // ---------------------------------------------------------------------
  // clock and timeout
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous upper bound, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("scancode_to_ascii_decoder test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // layout tables, spanish keyboard
  // ---------------------------------------------------------------------

  // unshifted layer, zero where the key has no character
  function automatic logic [6:0] plain_char(input logic [6:0] k);
    case (k)
      7'h02: return 7'h31;  7'h03: return 7'h32;  7'h04: return 7'h33;
      7'h05: return 7'h34;  7'h06: return 7'h35;  7'h07: return 7'h36;
      7'h08: return 7'h37;  7'h09: return 7'h38;  7'h0A: return 7'h39;
      7'h0B: return 7'h30;  7'h0C: return 7'h27;  7'h0E: return 7'h08;
      7'h0F: return 7'h09;
      7'h10: return 7'h71;  7'h11: return 7'h77;  7'h12: return 7'h65;
      7'h13: return 7'h72;  7'h14: return 7'h74;  7'h15: return 7'h79;
      7'h16: return 7'h75;  7'h17: return 7'h69;  7'h18: return 7'h6F;
      7'h19: return 7'h70;  7'h1A: return 7'h60;  7'h1B: return 7'h2B;
      7'h1C: return 7'h0A;
      7'h1E: return 7'h61;  7'h1F: return 7'h73;  7'h20: return 7'h64;
      7'h21: return 7'h66;  7'h22: return 7'h67;  7'h23: return 7'h68;
      7'h24: return 7'h6A;  7'h25: return 7'h6B;  7'h26: return 7'h6C;
      7'h2C: return 7'h7A;  7'h2D: return 7'h78;  7'h2E: return 7'h63;
      7'h2F: return 7'h76;  7'h30: return 7'h62;  7'h31: return 7'h6E;
      7'h32: return 7'h6D;  7'h33: return 7'h2C;  7'h34: return 7'h2E;
      7'h35: return 7'h2D;  7'h37: return 7'h2A;  7'h39: return 7'h20;
      // keypad
      7'h47: return 7'h37;  7'h48: return 7'h38;  7'h49: return 7'h39;
      7'h4A: return 7'h2D;  7'h4B: return 7'h34;  7'h4C: return 7'h35;
      7'h4D: return 7'h36;  7'h4E: return 7'h2B;  7'h4F: return 7'h31;
      7'h50: return 7'h32;  7'h51: return 7'h33;  7'h52: return 7'h30;
      7'h53: return 7'h2E;
      7'h56: return 7'h3C;
      default: return 7'h00;
    endcase
  endfunction

  // shifted layer: letters go upper case, symbol keys listed, the rest
  // (keypad, space, enter, tab, backspace) match the plain layer
  function automatic logic [6:0] shifted_char(input logic [6:0] k);
    logic [6:0] p;
    p = plain_char(k);
    case (k)
      7'h02: return 7'h21;  7'h03: return 7'h22;  7'h04: return 7'h00;
      7'h05: return 7'h24;  7'h06: return 7'h25;  7'h07: return 7'h26;
      7'h08: return 7'h2F;  7'h09: return 7'h28;  7'h0A: return 7'h29;
      7'h0B: return 7'h3D;  7'h0C: return 7'h3F;  7'h1A: return 7'h5E;
      7'h1B: return 7'h2A;  7'h33: return 7'h3B;  7'h34: return 7'h3A;
      7'h35: return 7'h5F;  7'h56: return 7'h3E;
      default: begin
        if (p >= ASC_LC_A && p <= ASC_LC_Z) return p - CASE_DIFF;
        return p;
      end
    endcase
  endfunction

  function automatic logic [6:0] altgr_char(input logic [6:0] k);
    case (k)
      7'h02: return 7'h7C;  7'h03: return 7'h40;  7'h04: return 7'h23;
      7'h05: return 7'h7E;  7'h09: return 7'h5B;  7'h0A: return 7'h5D;
      7'h0C: return 7'h5C;  7'h28: return 7'h7B;  7'h2B: return 7'h7D;
      default: return 7'h00;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // predictor: updates the mirrored keyboard state and returns 1 when
  // the scancode should produce a key event
  // ---------------------------------------------------------------------
  function automatic bit decode_scancode(input logic [7:0] sc, output key_event_t ev);
    logic [6:0] k;
    logic [6:0] c;
    k  = sc[6:0];
    ev = '0;

    // extended prefix, also when one is already pending
    if (sc == SC_EXT_PREFIX) begin
      kb_prefix = 1'b1;
      return 1'b0;
    end

    // release: only modifiers care, prefix always consumed
    if (sc[SC_REL_BIT]) begin
      if (kb_prefix) begin
        if (k == SC_ALT)  kb_altgr = 1'b0;
        if (k == SC_CTRL) kb_ctrl  = 1'b0;
      end else begin
        if (k == SC_LSHIFT || k == SC_RSHIFT) kb_shift = 1'b0;
        if (k == SC_CTRL) kb_ctrl = 1'b0;
      end
      kb_prefix = 1'b0;
      return 1'b0;
    end

    // extended press: altgr, right ctrl, navigation keys
    if (kb_prefix) begin
      kb_prefix = 1'b0;
      ev.is_special = 1'b1;
      case (k)
        SC_ALT:   begin kb_altgr = 1'b1; return 1'b0; end
        SC_CTRL:  begin kb_ctrl  = 1'b1; return 1'b0; end
        SC_UP:    ev.special_key = SK_UP;
        SC_DOWN:  ev.special_key = SK_DOWN;
        SC_LEFT:  ev.special_key = SK_LEFT;
        SC_RIGHT: ev.special_key = SK_RIGHT;
        SC_HOME:  ev.special_key = SK_HOME;
        SC_END:   ev.special_key = SK_END;
        default:  return 1'b0;
      endcase
      return 1'b1;
    end

    // plain modifiers
    if (k == SC_LSHIFT || k == SC_RSHIFT) begin
      kb_shift = 1'b1;
      return 1'b0;
    end
    if (k == SC_CTRL) begin
      kb_ctrl = 1'b1;
      return 1'b0;
    end
    if (k == SC_CAPS) begin
      kb_caps = ~kb_caps;
      return 1'b0;
    end

    // tab ignores every modifier
    if (k == SC_TAB) begin
      ev.is_special  = 1'b1;
      ev.special_key = SK_TAB;
      return 1'b1;
    end

    // priority: altgr, then ctrl, then shift / caps
    if (kb_altgr) begin
      c = altgr_char(k);
    end else if (kb_ctrl) begin
      c = plain_char(k);
      if (c >= ASC_LC_A && c <= ASC_LC_Z) c = c - LC_CTRL_OFS;
      else if (c >= ASC_UC_A && c <= ASC_UC_Z) c = c - UC_CTRL_OFS;
      else c = 7'h00;
    end else if (kb_shift) begin
      c = shifted_char(k);
    end else begin
      c = plain_char(k);
      if (kb_caps && c >= ASC_LC_A && c <= ASC_LC_Z) c = c - CASE_DIFF;
    end

    if (c == 7'h00) return 1'b0;
    ev.char_code = c;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // sender: one scancode per transaction, bursts with random gaps
  // ---------------------------------------------------------------------
  task automatic send_scancode(input logic [7:0] sc);
    int         gap;
    key_event_t ev;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.scan_byte <= sc;
    // ready is stable mid-cycle, the transaction lands on the next edge
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    if (decode_scancode(sc, ev)) pending_keys.push_back(ev);
  endtask

  // ---------------------------------------------------------------------
  // receiver back-pressure, in randomly chosen patterns
  // ---------------------------------------------------------------------
  initial begin
    stall_mode_e mode;
    int          left;
    int          phase;
    out_ch.ready <= 1'b0;
    mode  = RDY_ALWAYS;
    left  = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        left = $urandom_range(40, 200);
      end
      left--;
      phase++;
      case (mode)
        RDY_ALWAYS:   out_ch.ready <= 1'b1;
        RDY_COIN:     out_ch.ready <= ($urandom_range(0, 1) == 1);
        RDY_MOSTLY:   out_ch.ready <= ($urandom_range(0, 7) != 0);
        default:      out_ch.ready <= ((phase % 7) < 4);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // checker: compare each output transaction against the oldest prediction
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    key_event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_keys.size() == 0) begin
        error_count++;
        $display("%0t: unexpected key event is_special=%0b char_code=%h special_key=%0d",
                 $time, out_ch.is_special, out_ch.char_code, out_ch.special_key);
      end else begin
        want = pending_keys.pop_front();
        if (out_ch.is_special !== want.is_special) begin
          error_count++;
          $display("%0t: is_special expected %0b actual %0b",
                   $time, want.is_special, out_ch.is_special);
        end
        if (out_ch.char_code !== want.char_code) begin
          error_count++;
          $display("%0t: char_code expected %h actual %h",
                   $time, want.char_code, out_ch.char_code);
        end
        if (out_ch.special_key !== want.special_key) begin
          error_count++;
          $display("%0t: special_key expected %0d actual %0d",
                   $time, want.special_key, out_ch.special_key);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------

  // field extremes, an unshifted letter, tab, unmapped codes
  task automatic test_plain_keys();
    send_scancode(8'h00);  // unmapped, lowest code
    send_scancode(8'h7F);  // unmapped, highest press code
    send_scancode(8'hFF);  // release of nothing
    send_scancode(8'h1E);  // a
    send_scancode(8'h0F);  // tab
  endtask

  // shift, ctrl and altgr each pressed and released, caps lock toggled on and off
  task automatic test_modifiers();
    send_scancode(8'h2A);  // left shift
    send_scancode(8'h1E);  // A
    send_scancode(8'h04);  // no shifted symbol on this key
    send_scancode(8'hAA);
    send_scancode(8'h3A);  // caps on
    send_scancode(8'h1E);  // A
    send_scancode(8'h02);  // digits untouched by caps
    send_scancode(8'h3A);  // caps off
    send_scancode(8'h1D);  // ctrl
    send_scancode(8'h2E);  // ctrl-c
    send_scancode(8'h02);  // ctrl with a non-letter
    send_scancode(8'h9D);
    send_scancode(8'hE0);  // altgr
    send_scancode(8'h38);
    send_scancode(8'h03);  // @
    send_scancode(8'hE0);
    send_scancode(8'hB8);
  endtask

  // repeated prefix, navigation keys, unknown extended key
  task automatic test_extended_keys();
    send_scancode(8'hE0);
    send_scancode(8'hE0);
    send_scancode(8'h48);  // up
    send_scancode(8'hE0);
    send_scancode(8'h4F);  // end
    send_scancode(8'hE0);
    send_scancode(8'h10);  // ignored extended press
  endtask

  // one well-formed keystroke with random modifiers around it
  task automatic send_keystroke();
    logic [6:0] key;
    logic [6:0] nav_keys[6];
    bit         use_shift;
    bit         use_ctrl;
    bit         use_altgr;
    bit         ext_ctrl;
    bit         rshift;
    nav_keys  = '{SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_HOME, SC_END};
    use_shift = ($urandom_range(0, 2) == 0);
    use_ctrl  = ($urandom_range(0, 4) == 0);
    use_altgr = ($urandom_range(0, 4) == 0);
    ext_ctrl  = $urandom_range(0, 1);
    rshift    = $urandom_range(0, 1);

    if ($urandom_range(0, 9) == 0) begin
      send_scancode({1'b0, SC_CAPS});
      send_scancode({1'b1, SC_CAPS});
    end
    if (use_shift) send_scancode({1'b0, rshift ? SC_RSHIFT : SC_LSHIFT});
    if (use_ctrl) begin
      if (ext_ctrl) send_scancode(SC_EXT_PREFIX);
      send_scancode({1'b0, SC_CTRL});
    end
    if (use_altgr) begin
      send_scancode(SC_EXT_PREFIX);
      send_scancode({1'b0, SC_ALT});
    end

    if ($urandom_range(0, 4) == 0) begin
      key = ($urandom_range(0, 3) != 0) ? nav_keys[$urandom_range(0, 5)]
                                        : 7'($urandom_range(0, 127));
      send_scancode(SC_EXT_PREFIX);
      send_scancode({1'b0, key});
      send_scancode(SC_EXT_PREFIX);
      send_scancode({1'b1, key});
    end else begin
      key = 7'($urandom_range(1, 8'h58));
      send_scancode({1'b0, key});
      if ($urandom_range(0, 5) == 0) send_scancode({1'b0, key});  // typematic repeat
      send_scancode({1'b1, key});
    end

    // now and then a modifier stays held into the next keystroke
    if (use_altgr && $urandom_range(0, 7) != 0) begin
      send_scancode(SC_EXT_PREFIX);
      send_scancode({1'b1, SC_ALT});
    end
    if (use_ctrl && $urandom_range(0, 7) != 0) begin
      if (ext_ctrl) send_scancode(SC_EXT_PREFIX);
      send_scancode({1'b1, SC_CTRL});
    end
    if (use_shift && $urandom_range(0, 7) != 0)
      send_scancode({1'b1, rshift ? SC_RSHIFT : SC_LSHIFT});
  endtask

  // mostly typing, with bursts of raw bytes mixed in
  task automatic test_random_typing();
    int start;
    int n;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 6) != 0) begin
        send_keystroke();
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_scancode(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    int waited;
    kb_shift    = 1'b0;
    kb_ctrl     = 1'b0;
    kb_altgr    = 1'b0;
    kb_caps     = 1'b0;
    kb_prefix   = 1'b0;
    error_count = 0;
    items_sent  = 0;
    burst_left  = 0;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.scan_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_keys();
    test_modifiers();
    test_extended_keys();
    test_random_typing();

    in_ch.valid <= 1'b0;

    // drain outstanding key events, then give the pipeline time to misbehave
    waited = 0;
    while (pending_keys.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_keys.size() != 0) begin
      error_count++;
      $display("%0t: %0d key events never arrived", $time, pending_keys.size());
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("scancode_to_ascii_decoder test passed");
    end else begin
      $display("scancode_to_ascii_decoder test failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/scd_pkg.sv
hw/rtl/scd_in_if.sv
hw/rtl/scd_out_if.sv
hw/rtl/scd_decode.sv
hw/rtl/scancode_to_ascii_decoder.sv
tb/tb_scancode_to_ascii_decoder.sv
